@@ design/bba_pkg.sv @@
// Buddy allocator package: sizing constants, codes, controller/datapath types.
// No dependencies; used by every other file of the block.
`default_nettype none

package bba_pkg;

  localparam int ORDERS          = 8;
  localparam int MIN_BLOCK_SHIFT = 6;
  localparam int TOP_BLOCKS      = 4;

  localparam int TOP_ORDER = ORDERS - 1;
  localparam int MAX_UNITS = TOP_BLOCKS << TOP_ORDER;

  localparam int OPC_W   = 1;
  localparam int BYTES_W = 16;
  localparam int OFF_W   = 9;
  localparam int STAT_W  = 2;
  localparam int ORD_W   = 3;
  localparam int TBE_W   = 4;
  localparam int LOG2_W  = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int UNITS_W   = $clog2(MAX_UNITS + 1);
  localparam int CNT_W     = $clog2(MAX_UNITS);
  localparam int BLK_W     = $clog2(TOP_BLOCKS + 1);
  localparam int WORDS0    = (MAX_UNITS + WORD_BITS - 1) >> BIT_W;
  localparam int WIDX_W    = (WORDS0 > 1) ? $clog2(WORDS0) : 1;

  // free-map words used by one order
  function automatic int fm_words(input int o);
    return ((MAX_UNITS >> o) + WORD_BITS - 1) >> BIT_W;
  endfunction

  // first free-map word of one order
  function automatic int fm_base(input int o);
    int s;
    s = 0;
    for (int k = 0; k < ORDERS; k++) begin
      if (k < o) s = s + fm_words(k);
    end
    return s;
  endfunction

  localparam int FM_DEPTH = fm_base(ORDERS);
  localparam int FMA_W    = $clog2(FM_DEPTH);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    RES_OK, RES_NO_FREE, RES_TOO_LARGE, RES_BAD_FREE
  } res_status_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLR_INIT, CMD_CLR_STEP, CMD_LOAD, CMD_SRCH_START, CMD_SRCH_RD,
    CMD_SRCH_NEXT_W, CMD_SRCH_NEXT_O, CMD_TAKE, CMD_SPLIT_RD, CMD_SPLIT_WR,
    CMD_TBL_WR_ALLOC, CMD_TBL_RD, CMD_FREE_START, CMD_BUD_RD, CMD_BUD_TAKE,
    CMD_FIN_RD, CMD_FIN_WR, CMD_RES_BIG, CMD_RES_NOFREE, CMD_RES_BADFREE, CMD_EMIT
  } dp_cmd_t;

  typedef enum logic [4:0] {
    ST_CLR_INIT, ST_CLEAR, ST_IDLE, ST_DECODE, ST_SRCH_RD, ST_SRCH_CHK,
    ST_SPLIT_RD, ST_SPLIT_WR, ST_ALLOC_WR, ST_TBL_CHK, ST_MERGE, ST_BUD_RD,
    ST_BUD_CHK, ST_FIN_RD, ST_FIN_WR, ST_DONE
  } bba_state_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic too_large;
    logic off_oob;
    logic word_hit;
    logic last_word;
    logic last_ord;
    logic split_more;
    logic tb_bad;
    logic bud_ok;
    logic bud_free;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ design/bba_ifs.sv @@
// Request and response channel interfaces of the buddy allocator.
// Depends on bba_pkg for field widths.
`default_nettype none

interface bba_req_if;
  import bba_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OPC_W-1:0]     opcode;
  logic [BYTES_W-1:0]   request_bytes;
  logic [OFF_W-1:0]     free_offset;
  modport source (output valid, opcode, request_bytes, free_offset, input ready);
  modport sink   (input valid, opcode, request_bytes, free_offset, output ready);
endinterface

interface bba_rsp_if;
  import bba_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [OFF_W-1:0]     block_offset;
  logic [ORD_W-1:0]     block_order;
  modport source (output valid, status, block_offset, block_order, input ready);
  modport sink   (input valid, status, block_offset, block_order, output ready);
endinterface

`default_nettype wire

@@ design/buddy_block_allocator_unit.sv @@
// Buddy block allocator top level: request/response channels, APB register.
// Depends on bba_pkg, bba_ifs, bba_ctrl and bba_dp.
//
// req carries allocate (opcode 0, request_bytes) or free (opcode 1,
// free_offset) commands; rsp returns one beat per request with status,
// block_offset and block_order. One request is in work at a time.
// An allocate scans up to 34 free-map words and splits as needed; a free
// merges upward while the buddy is free; too-large and out-of-heap
// requests and frees of an unallocated offset end without either.
// Search, split and merge read-modify-writes share the single free-map
// port.
// The finished result sits in an output register; a new request is taken
// while it waits, but the following result stalls until rsp takes it.
// Reset, or a write of heap_top_blocks_log2 (addresses 0 to 3), starts a
// clearing pass over the order table and free map during which req is
// not ready; reset sets heap_top_blocks_log2 to 2.
`default_nettype none

module buddy_block_allocator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bba_pkg::PADDR_W-1:0]   paddr,
  input  logic [bba_pkg::PDATA_W-1:0]   pwdata,
  output logic [bba_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  bba_req_if.sink                       req,
  bba_rsp_if.source                     rsp
);
  import bba_pkg::*;

  logic [LOG2_W-1:0] heap_log2;
  logic              cfg_wr;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[PADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_log2 <= LOG2_W'(2);
    end else if (cfg_wr) begin
      heap_log2 <= pwdata[LOG2_W-1:0];
    end
  end

  assign prdata = paddr[PADDR_W-1] ? '0 : PDATA_W'(heap_log2);

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .heap_log2  (heap_log2),
    .in_opcode  (req.opcode),
    .in_bytes   (req.request_bytes),
    .in_offset  (req.free_offset),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_status (rsp.status),
    .out_offset (rsp.block_offset),
    .out_order  (rsp.block_order)
  );

endmodule

`default_nettype wire

@@ design/bba_ctrl.sv @@
// Buddy allocator sequencer: walks clear, search, split and merge steps.
// Depends on bba_pkg; drives bba_dp through dp_cmd_t, reads dp_stat_t.
`default_nettype none

module bba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr,
  input  logic              in_valid,
  output logic              in_ready,
  input  bba_pkg::dp_stat_t stat,
  output bba_pkg::dp_cmd_t  cmd
);
  import bba_pkg::*;

  bba_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLR_INIT: begin
        cmd        = CMD_CLR_INIT;
        state_next = ST_CLEAR;
      end
      ST_CLEAR: begin
        cmd = CMD_CLR_STEP;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.is_free) begin
          if (stat.off_oob) begin
            cmd        = CMD_RES_BADFREE;
            state_next = ST_DONE;
          end else begin
            cmd        = CMD_TBL_RD;
            state_next = ST_TBL_CHK;
          end
        end else if (stat.too_large) begin
          cmd        = CMD_RES_BIG;
          state_next = ST_DONE;
        end else begin
          cmd        = CMD_SRCH_START;
          state_next = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        cmd        = CMD_SRCH_RD;
        state_next = ST_SRCH_CHK;
      end
      ST_SRCH_CHK: begin
        if (stat.word_hit) begin
          cmd        = CMD_TAKE;
          state_next = stat.split_more ? ST_SPLIT_RD : ST_ALLOC_WR;
        end else if (!stat.last_word) begin
          cmd        = CMD_SRCH_NEXT_W;
          state_next = ST_SRCH_RD;
        end else if (!stat.last_ord) begin
          cmd        = CMD_SRCH_NEXT_O;
          state_next = ST_SRCH_RD;
        end else begin
          cmd        = CMD_RES_NOFREE;
          state_next = ST_DONE;
        end
      end
      ST_SPLIT_RD: begin
        cmd        = CMD_SPLIT_RD;
        state_next = ST_SPLIT_WR;
      end
      ST_SPLIT_WR: begin
        cmd        = CMD_SPLIT_WR;
        state_next = stat.split_more ? ST_SPLIT_RD : ST_ALLOC_WR;
      end
      ST_ALLOC_WR: begin
        cmd        = CMD_TBL_WR_ALLOC;
        state_next = ST_DONE;
      end
      ST_TBL_CHK: begin
        if (stat.tb_bad) begin
          cmd        = CMD_RES_BADFREE;
          state_next = ST_DONE;
        end else begin
          cmd        = CMD_FREE_START;
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin
        state_next = stat.bud_ok ? ST_BUD_RD : ST_FIN_RD;
      end
      ST_BUD_RD: begin
        cmd        = CMD_BUD_RD;
        state_next = ST_BUD_CHK;
      end
      ST_BUD_CHK: begin
        if (stat.bud_free) begin
          cmd        = CMD_BUD_TAKE;
          state_next = ST_MERGE;
        end else begin
          state_next = ST_FIN_RD;
        end
      end
      ST_FIN_RD: begin
        cmd        = CMD_FIN_RD;
        state_next = ST_FIN_WR;
      end
      ST_FIN_WR: begin
        cmd        = CMD_FIN_WR;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd        = CMD_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLR_INIT;
    endcase
    if (cfg_wr) begin
      cmd        = CMD_NONE;
      in_ready   = 1'b0;
      state_next = ST_CLR_INIT;
    end
  end

endmodule

`default_nettype wire

@@ design/bba_dp.sv @@
// Buddy allocator datapath: free-map and order-table memories, walk registers,
// result and output registers. Depends on bba_pkg; commanded by bba_ctrl.
`default_nettype none

module bba_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  bba_pkg::dp_cmd_t              cmd,
  output bba_pkg::dp_stat_t             stat,
  input  logic [bba_pkg::LOG2_W-1:0]    heap_log2,
  input  logic [bba_pkg::OPC_W-1:0]     in_opcode,
  input  logic [bba_pkg::BYTES_W-1:0]   in_bytes,
  input  logic [bba_pkg::OFF_W-1:0]     in_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bba_pkg::STAT_W-1:0]    out_status,
  output logic [bba_pkg::OFF_W-1:0]     out_offset,
  output logic [bba_pkg::ORD_W-1:0]     out_order
);
  import bba_pkg::*;

  logic [WORD_BITS-1:0] fm [FM_DEPTH];
  logic [TBE_W-1:0]     tb [MAX_UNITS];

  logic                 op_r;
  logic [ORD_W-1:0]     need_r;
  logic                 big_r;
  logic [OFF_W-1:0]     req_off;
  logic [ORD_W-1:0]     ord;
  logic [WIDX_W-1:0]    widx;
  logic [OFF_W-1:0]     off;
  logic [CNT_W-1:0]     clr_cnt;
  logic [WORD_BITS-1:0] fm_rd;
  logic [TBE_W-1:0]     tb_rd;
  res_status_t          res_status;
  logic [OFF_W-1:0]     res_off;
  logic [ORD_W-1:0]     res_ord;

  logic [BLK_W-1:0]     blocks;
  logic [UNITS_W-1:0]   units;
  logic [WORD_BITS-1:0] init_mask;
  logic [ORD_W-1:0]     need_in;
  logic                 big_in;
  logic [OFF_W-1:0]     buddy;
  logic [OFF_W-1:0]     bud_blk;
  logic [BIT_W-1:0]     hit_bit;
  logic [ORD_W-1:0]     a_ord;
  logic [OFF_W-1:0]     a_off;
  logic [OFF_W-1:0]     a_blk;
  logic [WIDX_W-1:0]    a_word;
  logic [BIT_W-1:0]     a_bit;
  logic [FMA_W-1:0]     fm_addr;
  logic                 fm_we;
  logic [WORD_BITS-1:0] fm_wd;
  logic                 fm_re;
  logic                 tb_we;
  logic [CNT_W-1:0]     tb_addr;
  logic [TBE_W-1:0]     tb_wd;

  always_comb begin
    if ((32'd1 << heap_log2) > 32'(TOP_BLOCKS)) begin
      blocks = BLK_W'(TOP_BLOCKS);
    end else begin
      blocks = BLK_W'(32'd1 << heap_log2);
    end
  end
  assign units     = UNITS_W'(blocks) << TOP_ORDER;
  assign init_mask = WORD_BITS'((64'd1 << blocks) - 64'd1);

  always_comb begin
    need_in = ORD_W'(TOP_ORDER);
    big_in  = 1'b1;
    for (int n = ORDERS - 1; n >= 0; n--) begin
      if (32'(in_bytes) <= (32'd1 << (MIN_BLOCK_SHIFT + n))) begin
        need_in = ORD_W'(n);
        big_in  = 1'b0;
      end
    end
  end

  assign buddy   = off ^ (OFF_W'(1) << ord);
  assign bud_blk = buddy >> ord;

  always_comb begin
    hit_bit = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (fm_rd[i]) hit_bit = BIT_W'(i);
    end
  end

  always_comb begin
    a_ord = ord;
    a_off = off;
    if (cmd == CMD_SPLIT_RD) a_ord = ord - ORD_W'(1);
    if (cmd == CMD_BUD_RD || cmd == CMD_BUD_TAKE) a_off = buddy;
    a_blk  = a_off >> a_ord;
    a_word = WIDX_W'(a_blk >> BIT_W);
    a_bit  = a_blk[BIT_W-1:0];
    if (cmd == CMD_SRCH_RD || cmd == CMD_TAKE) a_word = widx;
  end

  always_comb begin
    fm_addr = FMA_W'(fm_base(int'(a_ord)) + int'(a_word));
    fm_we   = 1'b0;
    fm_re   = 1'b0;
    fm_wd   = fm_rd;
    tb_we   = 1'b0;
    tb_addr = req_off;
    tb_wd   = '0;
    unique case (cmd)
      CMD_CLR_STEP: begin
        fm_addr = FMA_W'(clr_cnt);
        fm_we   = 32'(clr_cnt) < FM_DEPTH;
        fm_wd   = (32'(clr_cnt) == fm_base(TOP_ORDER)) ? init_mask : '0;
        tb_we   = 1'b1;
        tb_addr = clr_cnt;
      end
      CMD_SRCH_RD, CMD_SPLIT_RD, CMD_BUD_RD, CMD_FIN_RD: fm_re = 1'b1;
      CMD_TAKE: begin
        fm_we = 1'b1;
        fm_wd = fm_rd & ~(WORD_BITS'(1) << hit_bit);
      end
      CMD_SPLIT_WR, CMD_FIN_WR: begin
        fm_we = 1'b1;
        fm_wd = fm_rd | (WORD_BITS'(1) << a_bit);
      end
      CMD_BUD_TAKE: begin
        fm_we = 1'b1;
        fm_wd = fm_rd & ~(WORD_BITS'(1) << a_bit);
      end
      CMD_TBL_WR_ALLOC: begin
        tb_we   = 1'b1;
        tb_addr = off;
        tb_wd   = TBE_W'(need_r) + TBE_W'(1);
      end
      CMD_FREE_START: tb_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fm_we) fm[fm_addr] <= fm_wd;
    if (fm_re) fm_rd <= fm[fm_addr];
  end

  always_ff @(posedge clk) begin
    if (tb_we) tb[tb_addr] <= tb_wd;
    if (cmd == CMD_TBL_RD) tb_rd <= tb[tb_addr];
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_CLR_INIT: clr_cnt <= '0;
      CMD_CLR_STEP: clr_cnt <= clr_cnt + CNT_W'(1);
      CMD_LOAD: begin
        op_r    <= in_opcode;
        need_r  <= need_in;
        big_r   <= big_in;
        req_off <= in_offset;
      end
      CMD_SRCH_START: begin
        ord  <= need_r;
        widx <= WIDX_W'(fm_words(int'(need_r)) - 1);
      end
      CMD_SRCH_NEXT_W: widx <= widx - WIDX_W'(1);
      CMD_SRCH_NEXT_O: begin
        ord  <= ord + ORD_W'(1);
        widx <= WIDX_W'(fm_words(int'(ord) + 1) - 1);
      end
      CMD_TAKE:     off <= OFF_W'({widx, hit_bit}) << ord;
      CMD_SPLIT_RD: ord <= ord - ORD_W'(1);
      CMD_SPLIT_WR: off <= off + (OFF_W'(1) << ord);
      CMD_TBL_WR_ALLOC: begin
        res_status <= RES_OK;
        res_off    <= off;
        res_ord    <= need_r;
      end
      CMD_FREE_START: begin
        ord    <= ORD_W'(tb_rd - TBE_W'(1));
        need_r <= ORD_W'(tb_rd - TBE_W'(1));
        off    <= req_off;
      end
      CMD_BUD_TAKE: begin
        off <= off & ~(OFF_W'(1) << ord);
        ord <= ord + ORD_W'(1);
      end
      CMD_FIN_WR: begin
        res_status <= RES_OK;
        res_off    <= req_off;
        res_ord    <= need_r;
      end
      CMD_RES_BIG: begin
        res_status <= RES_TOO_LARGE;
        res_off    <= '0;
        res_ord    <= '0;
      end
      CMD_RES_NOFREE: begin
        res_status <= RES_NO_FREE;
        res_off    <= '0;
        res_ord    <= '0;
      end
      CMD_RES_BADFREE: begin
        res_status <= RES_BAD_FREE;
        res_off    <= req_off;
        res_ord    <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_EMIT) begin
      out_status <= res_status;
      out_offset <= res_off;
      out_order  <= res_ord;
    end
  end

  assign stat.clr_last   = (clr_cnt == CNT_W'(MAX_UNITS - 1));
  assign stat.is_free    = (op_r == OP_FREE);
  assign stat.too_large  = big_r;
  assign stat.off_oob    = (UNITS_W'(req_off) >= units);
  assign stat.word_hit   = |fm_rd;
  assign stat.last_word  = (widx == '0);
  assign stat.last_ord   = (ord == ORD_W'(TOP_ORDER));
  assign stat.split_more = (ord > need_r);
  assign stat.tb_bad     = (tb_rd == '0) || (tb_rd > TBE_W'(ORDERS));
  assign stat.bud_ok     = (ord < ORD_W'(TOP_ORDER)) && (UNITS_W'(buddy) < units);
  assign stat.bud_free   = fm_rd[bud_blk[BIT_W-1:0]];
  assign stat.out_free   = !out_valid || out_ready;

`ifndef SYNTH
  a_split_above_need: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_SPLIT_RD) |-> (ord > need_r))
    else $error("split below requested order");
  a_grant_aligned: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_TBL_WR_ALLOC) |-> (((off >> need_r) << need_r) == off))
    else $error("granted block not aligned to its order");
  a_split_half_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_SPLIT_WR) |-> !fm_rd[a_bit])
    else $error("split half already marked free");
  a_free_not_free: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_FIN_WR) |-> !fm_rd[a_bit])
    else $error("freed block already marked free");
`endif

endmodule

`default_nettype wire

@@ test/bba_scoreboard.sv @@
// Scoreboard for the buddy allocator: own free map and order table, expected beats.
// Depends on bba_pkg.
`timescale 1ns / 100ps

import bba_pkg::*;

typedef struct packed {
  logic [STAT_W-1:0] status;
  logic [OFF_W-1:0]  offset;
  logic [ORD_W-1:0]  order;
} alloc_result_t;

class bba_scoreboard;
  bit            free_bits[ORDERS][MAX_UNITS];
  int            granted[MAX_UNITS];
  int            heap_log2;
  alloc_result_t pending[$];
  int            mismatches;
  int            checked;
  int            live[$];

  function void rebuild(int log2v);
    int blocks;
    heap_log2 = log2v & 3;
    foreach (free_bits[o, u]) free_bits[o][u] = 0;
    foreach (granted[u]) granted[u] = 0;
    live.delete();
    blocks = 1 << heap_log2;
    if (blocks > TOP_BLOCKS) blocks = TOP_BLOCKS;
    for (int b = 0; b < blocks; b++) free_bits[TOP_ORDER][b] = 1;
  endfunction

  function int heap_units();
    int blocks;
    blocks = 1 << heap_log2;
    if (blocks > TOP_BLOCKS) blocks = TOP_BLOCKS;
    return blocks << TOP_ORDER;
  endfunction

  function alloc_result_t allocate(int bytes);
    alloc_result_t r;
    int need, ord, off, idx;
    bit found;
    r = '0;
    need = 0;
    found = 0;
    off = 0;
    while (need < ORDERS && (longint'(1) << (MIN_BLOCK_SHIFT + need)) < bytes) need++;
    if (need >= ORDERS) begin
      r.status = RES_TOO_LARGE;
      return r;
    end
    for (ord = need; ord < ORDERS; ord++) begin
      for (idx = (heap_units() >> ord) - 1; idx >= 0; idx--) begin
        if (free_bits[ord][idx]) begin
          found = 1;
          off = idx << ord;
          break;
        end
      end
      if (found) break;
    end
    if (!found) begin
      r.status = RES_NO_FREE;
      return r;
    end
    free_bits[ord][off >> ord] = 0;
    while (ord > need) begin
      ord--;
      free_bits[ord][off >> ord] = 1;
      off += 1 << ord;
    end
    granted[off] = need + 1;
    live.push_back(off);
    r.status = RES_OK;
    r.offset = OFF_W'(off);
    r.order = ORD_W'(need);
    return r;
  endfunction

  function alloc_result_t release_block(int offset);
    alloc_result_t r;
    int ord, off, bud, g;
    r = '0;
    r.offset = OFF_W'(offset);
    if (offset >= heap_units() || granted[offset] == 0) begin
      r.status = RES_BAD_FREE;
      return r;
    end
    g = granted[offset] - 1;
    granted[offset] = 0;
    foreach (live[i]) if (live[i] == offset) begin
      live.delete(i);
      break;
    end
    ord = g;
    off = offset;
    while (ord < TOP_ORDER) begin
      bud = off ^ (1 << ord);
      if (bud >= heap_units() || !free_bits[ord][bud >> ord]) break;
      free_bits[ord][bud >> ord] = 0;
      off &= ~(1 << ord);
      ord++;
    end
    free_bits[ord][off >> ord] = 1;
    r.status = RES_OK;
    r.order = ORD_W'(g);
    return r;
  endfunction

  function void note_request(logic opc, int bytes, int offset);
    if (opc == OP_ALLOC) pending.push_back(allocate(bytes));
    else pending.push_back(release_block(offset));
  endfunction

  function void check_result(alloc_result_t got);
    alloc_result_t exp;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected beat: %p", got);
      return;
    end
    exp = pending.pop_front();
    if (got !== exp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected st=%0d off=%0d ord=%0d, got st=%0d off=%0d ord=%0d",
                 exp.status, exp.offset, exp.order, got.status, got.offset, got.order);
    end
  endfunction
endclass

@@ test/testbench.sv @@
// Testbench top for buddy_block_allocator_unit: directed and random allocate/free beats.
// Depends on bba_pkg, bba_ifs and bba_scoreboard.
`timescale 1ns / 100ps

module testbench;
  import bba_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  bba_req_if req ();
  bba_rsp_if rsp ();

  bba_scoreboard heap_sb = new();
  int sent;
  int rsp_wait;
  bit driving_done;

  buddy_block_allocator_unit DUT (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req(req), .rsp(rsp)
  );

  always #5 clk = ~clk;

  initial begin
    req.valid = 0;
    req.opcode = '0;
    req.request_bytes = '0;
    req.free_offset = '0;
    rsp.ready = 0;
  end

  task automatic send(logic opc, int bytes, int offset);
    repeat ($urandom_range(0, 8)) @(negedge clk);
    req.valid = 1;
    req.opcode = opc;
    req.request_bytes = bytes[BYTES_W-1:0];
    req.free_offset = offset[OFF_W-1:0];
    do @(posedge clk); while (!req.ready);
    heap_sb.note_request(opc, bytes & 32'hFFFF, offset & 32'h1FF);
    sent++;
    @(negedge clk);
    req.valid = 0;
  endtask

  task automatic write_heap_log2(int value);
    while (heap_sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= '0;
    pwdata <= value;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    heap_sb.rebuild(value);
  endtask

  task automatic random_burst(int count);
    int kind, sel;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        sel = $urandom_range(0, 9);
        if (sel < 6) send(OP_ALLOC, $urandom_range(0, 1 << (MIN_BLOCK_SHIFT + 3)),
                          $urandom);
        else if (sel < 9) send(OP_ALLOC, $urandom_range(0, 8192), $urandom);
        else send(OP_ALLOC, $urandom_range(0, 65535), $urandom);
      end else if (kind < 90 && heap_sb.live.size() != 0) begin
        send(OP_FREE, $urandom, heap_sb.live[$urandom_range(0, heap_sb.live.size() - 1)]);
      end else begin
        send(OP_FREE, $urandom, $urandom_range(0, 511));
      end
    end
  endtask

  always begin
    @(negedge clk);
    rsp_wait = $urandom_range(0, 8);
    if (rsp_wait != 0) begin
      rsp.ready <= 0;
      repeat (rsp_wait) @(negedge clk);
    end
    rsp.ready <= 1;
    do @(posedge clk); while (!(rsp.valid && !rst));
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      heap_sb.check_result('{rsp.status, rsp.block_offset, rsp.block_order});
  end

  initial begin
    heap_sb.rebuild(2);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // extremes and special cases
    send(OP_ALLOC, 0, 0);
    send(OP_ALLOC, 65535, 511);
    send(OP_ALLOC, 8193, 0);
    send(OP_ALLOC, 8192, 0);
    send(OP_ALLOC, 64, 0);
    send(OP_ALLOC, 65, 0);
    send(OP_FREE, 0, 511);
    send(OP_FREE, 65535, 0);
    send(OP_FREE, 0, 384);
    send(OP_FREE, 0, 384);
    for (int i = 0; i < 5; i++) send(OP_ALLOC, 8192, 0);
    while (heap_sb.live.size() != 0) send(OP_FREE, 0, heap_sb.live[0]);
    write_heap_log2(0);
    send(OP_ALLOC, 8192, 0);
    send(OP_ALLOC, 1, 0);
    send(OP_FREE, 0, 128);
    send(OP_FREE, 0, 0);
    random_burst(400);
    write_heap_log2(3);
    random_burst(400);
    write_heap_log2(1);
    random_burst(400);
    write_heap_log2(2);
    random_burst(430);
    while (heap_sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("covered %0d requests, %0d result beats checked, 4 heap sizes",
             sent, heap_sb.checked);
    if (heap_sb.mismatches == 0 && heap_sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule
